@@ hw/rtl/tms_pkg.sv @@
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants for the tabu move selector
// Item layouts, command and choice codes, tabu list control bundles.
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int TABU_DEPTH = 32;
	localparam int KEY_BITS   = 32;
	localparam int VAL_BITS   = 32;
	localparam int TEN_W      = 6;
	localparam int CNT_W      = 6;
	localparam int FILL_W     = $clog2(TABU_DEPTH + 1);

	localparam logic [TEN_W-1:0] TENURE_RESET = TEN_W'(15);

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic signed [VAL_BITS-1:0] val_t;

	typedef enum logic [1:0] {
		CMD_INIT = 2'd0,
		CMD_CAND = 2'd1,
		CMD_OBJ  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NORMAL  = 2'd0,
		KIND_ASPIRED = 2'd1,
		KIND_FORCED  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] command;
		key_t       move_key;
		val_t       move_delta;
		val_t       objective_value;
		logic       last_candidate;
	} cand_item_t;

	typedef struct packed {
		key_t             chosen_key;
		val_t             chosen_delta;
		kind_t            choice_kind;
		logic [CNT_W-1:0] tabu_count;
	} choice_item_t;

	// list update request from the selector
	typedef struct packed {
		logic append;
		logic drop;
		key_t key;
	} lst_op_t;

	// list status back to the selector
	typedef struct packed {
		logic              hit;
		logic [FILL_W-1:0] fill;
		logic [FILL_W-1:0] fill_next;
		key_t              oldest;
	} lst_stat_t;

endpackage

@@ hw/rtl/tms_cand_if.sv @@
// ----------------------------------------------------------------------------
// tms_cand_if: candidate channel
// Valid/ready channel carrying one command or candidate move.
// ----------------------------------------------------------------------------
interface tms_cand_if;
	logic                   valid;
	logic                   ready;
	tms_pkg::cand_item_t    data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/tms_choice_if.sv @@
// ----------------------------------------------------------------------------
// tms_choice_if: choice channel
// Valid/ready channel carrying the move selected for one round.
// ----------------------------------------------------------------------------
interface tms_choice_if;
	logic                   valid;
	logic                   ready;
	tms_pkg::choice_item_t  data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/tms_cell.sv @@
// ----------------------------------------------------------------------------
// tms_cell: one tabu list slot
// Holds one key, takes its right neighbor's key on a shift, loads a new key
// on a write, and flags a match against the probe key.
// ----------------------------------------------------------------------------
module tms_cell (
	input  logic          clk,
	input  logic          shift,
	input  logic          wr_en,
	input  tms_pkg::key_t wr_key,
	input  tms_pkg::key_t nb_key,
	input  tms_pkg::key_t cmp_key,
	input  logic          occupied,
	output tms_pkg::key_t key_q,
	output logic          hit
);
	import tms_pkg::*;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr_key;
		end else if (shift) begin
			key_q <= nb_key;
		end
	end

	assign hit = occupied && (key_q == cmp_key);

endmodule

@@ hw/rtl/tms_list.sv @@
// ----------------------------------------------------------------------------
// tms_list: tabu FIFO as a chain of cells
// Oldest key sits in cell 0; a drop shifts the chain toward cell 0, an
// append writes at the fill position. All cells compare the probe key.
// ----------------------------------------------------------------------------
module tms_list (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tms_pkg::TEN_W-1:0]  tenure,
	input  tms_pkg::key_t              cmp_key,
	input  tms_pkg::lst_op_t           op,
	output tms_pkg::lst_stat_t         stat
);
	import tms_pkg::*;

	localparam int CMP_W = (FILL_W > TEN_W) ? FILL_W : TEN_W;

	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_next;
	logic [CMP_W-1:0]      limit;
	logic                  full;
	logic                  shift;
	logic                  wr;
	logic [FILL_W-1:0]     wr_pos;
	key_t                  cell_key [TABU_DEPTH];
	key_t                  nb_key   [TABU_DEPTH];
	logic [TABU_DEPTH-1:0] hits;

	// effective tenure clamped to 1..depth
	always_comb begin
		if (tenure == '0) begin
			limit = CMP_W'(1);
		end else if (CMP_W'(tenure) > CMP_W'(TABU_DEPTH)) begin
			limit = CMP_W'(TABU_DEPTH);
		end else begin
			limit = CMP_W'(tenure);
		end
	end

	assign full = CMP_W'(fill_q) >= limit;

	always_comb begin
		shift     = 1'b0;
		wr        = 1'b0;
		wr_pos    = fill_q;
		fill_next = fill_q;
		if (op.append) begin
			wr = 1'b1;
			if (full) begin
				// drop oldest and write into the slot freed at the tail
				shift  = 1'b1;
				wr_pos = fill_q - FILL_W'(1);
			end else begin
				fill_next = fill_q + FILL_W'(1);
			end
		end else if (op.drop && fill_q != '0) begin
			shift     = 1'b1;
			fill_next = fill_q - FILL_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_next;
		end
	end

	for (genvar i = 0; i < TABU_DEPTH; i++) begin : g_cell
		if (i == TABU_DEPTH - 1) begin : g_tail
			assign nb_key[i] = cell_key[i];
		end else begin : g_mid
			assign nb_key[i] = cell_key[i+1];
		end

		tms_cell u_cell (
			.clk      (clk),
			.shift    (shift),
			.wr_en    (wr && (wr_pos == FILL_W'(i))),
			.wr_key   (op.key),
			.nb_key   (nb_key[i]),
			.cmp_key  (cmp_key),
			.occupied (FILL_W'(i) < fill_q),
			.key_q    (cell_key[i]),
			.hit      (hits[i])
		);
	end

	assign stat.hit       = |hits;
	assign stat.fill      = fill_q;
	assign stat.fill_next = fill_next;
	assign stat.oldest    = cell_key[0];

	ap_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		FILL_W'(TABU_DEPTH) >= fill_q)
		else $error("tabu fill above depth");

endmodule

@@ hw/rtl/tabu_move_selector.sv @@
// ----------------------------------------------------------------------------
// tabu_move_selector: tabu search move selection with aspiration
// A result passes the input register, then the output register; the tabu
// compare, aspiration add and list update all sit in the single stage between.
// Throughput: one transaction per cycle; a last candidate stalls on a held result.
// Reset: arst_n clears the tabu fill count, objectives and round state and
// sets the tenure to 15; list cells need no clearing.
// ----------------------------------------------------------------------------
module tabu_move_selector (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tenure_we,
	input  logic [tms_pkg::TEN_W-1:0] tenure_wd,
	tms_cand_if.sink                  cand,
	tms_choice_if.source              choice
);
	import tms_pkg::*;

	logic [TEN_W-1:0]   tenure_q;
	logic               busy_s1;
	cand_item_t         item_s1;

	val_t               cur_obj_q;
	val_t               best_obj_q;
	key_t               round_key_q;
	val_t               round_delta_q;
	logic               round_found_q;
	logic               round_asp_q;

	logic               out_valid_q;
	choice_item_t       out_q;

	lst_op_t            lop;
	lst_stat_t          lstat;

	logic               need_out;
	logic               fire;
	logic               aspire_ok;
	logic signed [VAL_BITS:0] trial;

	key_t               nx_key;
	val_t               nx_delta;
	logic               nx_found;
	logic               nx_asp;

	assign need_out = busy_s1 && item_s1.command == CMD_CAND && item_s1.last_candidate;
	assign fire     = busy_s1 && !(need_out && out_valid_q && !choice.ready);

	assign cand.ready   = !busy_s1 || fire;
	assign choice.valid = out_valid_q;
	assign choice.data  = out_q;

	// 33-bit sum cannot wrap
	assign trial     = $signed({cur_obj_q[VAL_BITS-1], cur_obj_q})
		+ $signed({item_s1.move_delta[VAL_BITS-1], item_s1.move_delta});
	assign aspire_ok = trial < $signed({best_obj_q[VAL_BITS-1], best_obj_q});

	always_comb begin
		nx_key   = round_key_q;
		nx_delta = round_delta_q;
		nx_found = round_found_q;
		nx_asp   = round_asp_q;
		if (lstat.hit) begin
			if (aspire_ok) begin
				nx_key   = item_s1.move_key;
				nx_delta = item_s1.move_delta;
				nx_found = 1'b1;
				nx_asp   = 1'b1;
			end
		end else if (!round_found_q || item_s1.move_delta < round_delta_q) begin
			nx_key   = item_s1.move_key;
			nx_delta = item_s1.move_delta;
			nx_found = 1'b1;
			nx_asp   = 1'b0;
		end
	end

	always_comb begin
		lop.append = fire && need_out && nx_found && !nx_asp;
		lop.drop   = fire && need_out && !nx_found;
		lop.key    = nx_key;
	end

	tms_list u_list (
		.clk     (clk),
		.arst_n  (arst_n),
		.tenure  (tenure_q),
		.cmp_key (item_s1.move_key),
		.op      (lop),
		.stat    (lstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tenure_q <= TENURE_RESET;
		end else if (tenure_we) begin
			tenure_q <= tenure_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (cand.ready) begin
			busy_s1 <= cand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cand.valid && cand.ready) begin
			item_s1 <= cand.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_obj_q     <= '0;
			best_obj_q    <= '0;
			round_key_q   <= '0;
			round_delta_q <= '0;
			round_found_q <= 1'b0;
			round_asp_q   <= 1'b0;
		end else if (fire) begin
			case (item_s1.command)
				CMD_INIT: begin
					cur_obj_q     <= item_s1.objective_value;
					best_obj_q    <= item_s1.objective_value;
					round_key_q   <= '0;
					round_delta_q <= '0;
					round_found_q <= 1'b0;
					round_asp_q   <= 1'b0;
				end
				CMD_OBJ: begin
					cur_obj_q <= item_s1.objective_value;
					if (item_s1.objective_value < best_obj_q) begin
						best_obj_q <= item_s1.objective_value;
					end
				end
				CMD_CAND: begin
					if (item_s1.last_candidate) begin
						round_key_q   <= '0;
						round_delta_q <= '0;
						round_found_q <= 1'b0;
						round_asp_q   <= 1'b0;
					end else begin
						round_key_q   <= nx_key;
						round_delta_q <= nx_delta;
						round_found_q <= nx_found;
						round_asp_q   <= nx_asp;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && need_out) begin
			out_valid_q <= 1'b1;
		end else if (choice.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && need_out) begin
			out_q.tabu_count <= CNT_W'(lstat.fill_next);
			if (nx_found) begin
				out_q.chosen_key   <= nx_key;
				out_q.chosen_delta <= nx_delta;
				out_q.choice_kind  <= nx_asp ? KIND_ASPIRED : KIND_NORMAL;
			end else begin
				out_q.chosen_key   <= (lstat.fill != '0) ? lstat.oldest : '0;
				out_q.chosen_delta <= '0;
				out_q.choice_kind  <= KIND_FORCED;
			end
		end
	end

	ap_asp_found: assert property (@(posedge clk) disable iff (!arst_n)
		round_asp_q |-> round_found_q)
		else $error("aspiration mark without a choice");

	ap_round_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fire && need_out |=> !round_found_q && !round_asp_q)
		else $error("round state not cleared after result");

	ap_forced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.choice_kind == KIND_FORCED |-> out_q.chosen_delta == '0)
		else $error("forced choice with nonzero delta");

	ap_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && need_out))
		else $error("result raised without a last candidate");

	ap_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.tabu_count <= CNT_W'(TABU_DEPTH))
		else $error("tabu count above depth");

endmodule
